// ===== rtl/assert_macros.svh =====
// Assertion helpers; every use assumes signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/msort_pkg.sv =====
package msort_pkg;

   // Width of the value fields on both channels.
   localparam int VALUE_W = 32;

endpackage

// ===== rtl/msort_req_if.sv =====
interface msort_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [msort_pkg::VALUE_W-1:0] value;
   logic                                 last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

// ===== rtl/msort_rsp_if.sv =====
interface msort_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [msort_pkg::VALUE_W-1:0] sorted_value;
   logic                                 end_of_set;
   logic                                 dropped;

   modport source (output valid, output sorted_value, output end_of_set, output dropped,
                   input ready);
   modport sink   (input valid, input sorted_value, input end_of_set, input dropped,
                   output ready);
endinterface

// ===== rtl/msort_mem.sv =====
module msort_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] wa,
   input  logic [WIDTH-1:0]         wd,
   input  logic [$clog2(DEPTH)-1:0] ra0,
   input  logic [$clog2(DEPTH)-1:0] ra1,
   output logic [WIDTH-1:0]         rd0,
   output logic [WIDTH-1:0]         rd1
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd0_ff;
   logic [WIDTH-1:0] rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wa] <= wd;
      end
   end

   always_ff @(posedge clock) begin
      rd0_ff <= store_ff[ra0];
      rd1_ff <= store_ff[ra1];
   end

   assign rd0 = rd0_ff;
   assign rd1 = rd1_ff;

endmodule

// ===== rtl/merge_sort_block.sv =====
// Collects a set of signed values and returns them in ascending order.
// req channel: one value per request; a request with last set closes the set.
//   Up to MAX_ITEMS values are kept, later ones are discarded and every result
//   of that set then carries dropped.
// rsp channel: the kept values in ascending order (stable), end_of_set on the
//   final one. A set always yields at least one result.
// Values are compared as DATA_WIDTH-bit two's complement numbers.
// Sorting is bottom-up merging between two stores, each with two registered read
// ports: ceil(log2 n) passes, one merged element per cycle, plus a closing check.
// Each result is read from the store, then held in the output register.
// req ready is high only while loading; the next set can start loading as soon
// as the final result of the previous set sits in the output register.
// When the receiver stalls, the output register holds and reads pause.
// Reset is synchronous: the block returns to loading with an empty set; the
// stores are not cleared, since only entries written for the current set are used.
`include "assert_macros.svh"

module merge_sort_block #(
   parameter int MAX_ITEMS  = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   msort_req_if.sink  req_if,
   msort_rsp_if.source rsp_if
);

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int WW = CW + 1;
   localparam int SW = CW + 2;
   localparam logic [CW-1:0] N_MAX = CW'(MAX_ITEMS);

   typedef enum logic [2:0] {
      S_LOAD, S_PASS, S_SETUP, S_PRIME, S_MERGE, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          ovf_ff, ovf_in;
   logic          src_sel_ff, src_sel_in;
   logic [WW-1:0] w_ff, w_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] mid_ff, mid_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] e_ff, e_in;
   logic          pend_ff, pend_in;
   logic [DATA_WIDTH-1:0] head_l_ff, head_l_in;
   logic [DATA_WIDTH-1:0] head_r_ff, head_r_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [msort_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_eos_ff, rsp_eos_in;
   logic          rsp_drop_ff, rsp_drop_in;

   logic                  req_acc;
   logic [DATA_WIDTH-1:0] value_d;
   logic [SW-1:0]         sum_mid, sum_hi, n_s;
   logic [CW-1:0]         mid_c, hi_c;
   logic                  left_av, right_av, take_l;
   logic [DATA_WIDTH-1:0] merge_d;

   logic                  a_we, b_we;
   logic [AW-1:0]         wa, ra0, ra1;
   logic [DATA_WIDTH-1:0] a_wd;
   logic [DATA_WIDTH-1:0] a_rd0, a_rd1, b_rd0, b_rd1, rd0, rd1;

   msort_mem #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_WIDTH)) u_store_a (
      .clock (clock),
      .we    (a_we),
      .wa    (wa),
      .wd    (a_wd),
      .ra0   (ra0),
      .ra1   (ra1),
      .rd0   (a_rd0),
      .rd1   (a_rd1)
   );

   msort_mem #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_WIDTH)) u_store_b (
      .clock (clock),
      .we    (b_we),
      .wa    (wa),
      .wd    (merge_d),
      .ra0   (ra0),
      .ra1   (ra1),
      .rd0   (b_rd0),
      .rd1   (b_rd1)
   );

   assign req_if.ready        = (state_ff == S_LOAD);
   assign req_acc             = req_if.valid && req_if.ready;
   assign value_d             = DATA_WIDTH'($unsigned(req_if.value));

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sorted_value = rsp_value_ff;
   assign rsp_if.end_of_set   = rsp_eos_ff;
   assign rsp_if.dropped      = rsp_drop_ff;

   assign rd0 = src_sel_ff ? b_rd0 : a_rd0;
   assign rd1 = src_sel_ff ? b_rd1 : a_rd1;

   // Run bounds, clipped to the set size.
   assign n_s     = SW'(fill_ff);
   assign sum_mid = SW'(lo_ff) + SW'(w_ff);
   assign sum_hi  = SW'(lo_ff) + (SW'(w_ff) << 1);
   assign mid_c   = (sum_mid < n_s) ? CW'(sum_mid) : fill_ff;
   assign hi_c    = (sum_hi < n_s) ? CW'(sum_hi) : fill_ff;

   // Left wins ties, which keeps the sort stable.
   assign left_av  = (i_ff < mid_ff);
   assign right_av = (j_ff < hi_ff);
   assign take_l   = left_av &&
                     (!right_av || ($signed(head_l_ff) <= $signed(head_r_ff)));
   assign merge_d  = take_l ? head_l_ff : head_r_ff;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      src_sel_in   = src_sel_ff;
      w_in         = w_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      pend_in      = pend_ff;
      head_l_in    = head_l_ff;
      head_r_in    = head_r_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_value_in = rsp_value_ff;
      rsp_eos_in   = rsp_eos_ff;
      rsp_drop_in  = rsp_drop_ff;
      a_we         = 1'b0;
      b_we         = 1'b0;
      wa           = k_ff[AW-1:0];
      a_wd         = merge_d;
      ra0          = '0;
      ra1          = '0;

      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (fill_ff != N_MAX) begin
                  a_we    = 1'b1;
                  wa      = fill_ff[AW-1:0];
                  a_wd    = value_d;
                  fill_in = fill_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_if.last) begin
                  state_in   = S_PASS;
                  w_in       = WW'(1);
                  src_sel_in = 1'b0;
               end
            end
         end
         S_PASS: begin
            if (w_ff >= WW'(fill_ff)) begin
               state_in = S_EMIT;
               e_in     = '0;
               pend_in  = 1'b0;
            end else begin
               lo_in    = '0;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            mid_in   = mid_c;
            hi_in    = hi_c;
            i_in     = lo_ff;
            j_in     = mid_c;
            k_in     = lo_ff;
            ra0      = lo_ff[AW-1:0];
            ra1      = mid_c[AW-1:0];
            state_in = S_PRIME;
         end
         S_PRIME: begin
            head_l_in = rd0;
            head_r_in = rd1;
            ra0       = AW'(i_ff + CW'(1));
            ra1       = AW'(j_ff + CW'(1));
            state_in  = S_MERGE;
         end
         S_MERGE: begin
            a_we = src_sel_ff;
            b_we = !src_sel_ff;
            if (take_l) begin
               i_in      = i_ff + CW'(1);
               head_l_in = rd0;
            end else begin
               j_in      = j_ff + CW'(1);
               head_r_in = rd1;
            end
            // Prefetch the entry after each new head.
            ra0  = AW'(i_in + CW'(1));
            ra1  = AW'(j_in + CW'(1));
            k_in = k_ff + CW'(1);
            if (k_in == hi_ff) begin
               if (sum_hi >= n_s) begin
                  src_sel_in = !src_sel_ff;
                  w_in       = w_ff << 1;
                  state_in   = S_PASS;
               end else begin
                  lo_in    = CW'(sum_hi);
                  state_in = S_SETUP;
               end
            end
         end
         S_EMIT: begin
            ra0 = e_ff[AW-1:0];
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = msort_pkg::VALUE_W'(rd0);
               rsp_eos_in   = (e_ff == fill_ff);
               rsp_drop_in  = ovf_ff;
               pend_in      = 1'b0;
               if (e_ff == fill_ff) begin
                  state_in = S_LOAD;
                  fill_in  = '0;
                  ovf_in   = 1'b0;
               end
            end else if (!rsp_valid_ff || rsp_if.ready) begin
               pend_in = 1'b1;
               e_in    = e_ff + CW'(1);
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         src_sel_ff   <= 1'b0;
         w_ff         <= '0;
         lo_ff        <= '0;
         mid_ff       <= '0;
         hi_ff        <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         e_ff         <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         src_sel_ff   <= src_sel_in;
         w_ff         <= w_in;
         lo_ff        <= lo_in;
         mid_ff       <= mid_in;
         hi_ff        <= hi_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         e_ff         <= e_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_l_ff    <= head_l_in;
      head_r_ff    <= head_r_in;
      rsp_value_ff <= rsp_value_in;
      rsp_eos_ff   <= rsp_eos_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   // Elements taken from both runs always add up to the output position.
   `ASSERT_IMP(a_merge_pos, state_ff == S_MERGE, (WW'(k_ff) + WW'(mid_ff)) == (WW'(i_ff) + WW'(j_ff)))
   `ASSERT_IMP(a_merge_bounds, state_ff == S_MERGE, (i_ff <= mid_ff) && (j_ff <= hi_ff) && (k_ff < hi_ff))
   `ASSERT_IMP(a_emit_nonempty, state_ff == S_EMIT, (fill_ff != '0) && (e_ff <= fill_ff))
   `ASSERT_NEXT(a_rsp_from_read, !rsp_valid_ff && !pend_ff, !rsp_valid_ff)

endmodule
